### rtl/hsm_pkg.sv
// Shared types and constants for the hourglass stencil minimum block.
// Used by the top level and the checker; depends on nothing.
package hsm_pkg;

    // Sample and sum widths follow the fixed payload format
    localparam int SAMPLE_BITS    = 16;
    localparam int SUM_BITS       = SAMPLE_BITS + 3;
    localparam int MIN_SUM_BITS   = 19;
    localparam int ROW_WIDTH_BITS = 8;

    // Default line buffer depth (longest row)
    localparam int HSM_MAX_WIDTH = 128;

    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 8'd128;

    // Saturation point of the completed-row count
    localparam logic [1:0] ROWS_FULL = 2'd3;
    localparam logic [1:0] ROWS_WINDOW = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [MIN_SUM_BITS-1:0] min_sum;
        logic                           too_small;
    } t_out_item;

endpackage

### rtl/hsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a same-cycle write. No dependencies.
module hsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read-old in the same clocked block
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hourglass_stencil_min_unit.sv
// Top level of the hourglass stencil minimum block.
// Depends on hsm_pkg and hsm_ram.

// Accepts one sample per clock cycle while the input is not stalled, with no
// gaps between rows or frames. An accepted sample looks up its column in two
// line-buffer RAMs of MAX_WIDTH entries each; their registered read port sets
// a two-register path: the sample enters the lookup register on acceptance,
// and the window shift, seven-term sum and minimum update happen when the
// update stage advances. The result for a frame is loaded into the output
// register when its last sample advances out of the lookup register. Input
// stall rises only when a frame result is held in the output register under
// stall and the next frame's last sample waits in the lookup register behind
// it. The line buffers need no clearing after reset.
module hourglass_stencil_min_unit
    import hsm_pkg::*;
#(
    parameter int MAX_WIDTH = HSM_MAX_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ROW_WIDTH_BITS-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > ROW_WIDTH_BITS) ? CW + 1 : ROW_WIDTH_BITS;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;

    // Configuration
    logic [ROW_WIDTH_BITS-1:0] r_row_width;

    // Frame position, updated on acceptance
    logic [CW-1:0] r_col, n_col;
    logic [1:0]    r_rows, n_rows;

    // Lookup stage
    logic          r_s1_valid;
    t_sample       r_s1_sample;
    logic [CW-1:0] r_s1_addr;
    logic          r_s1_win;
    logic          r_s1_last;
    logic          r_s1_fwd;
    t_sample       r_s1_fwd_data;

    // Window and running minimum
    t_sample r_win [3][3];
    t_sum    r_min, n_min;
    logic    r_have_min, n_have_min;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic          accept, s1_adv;
    logic [WW-1:0] w_eff, col_ext, c_ext, c_inc;
    logic [CW-1:0] c_idx;
    logic          row_end, win_ok;
    t_sample       rd_above, rd_two, up1, up2;
    t_sum          sum;

    // Handshake: the update stage holds only behind a stalled result
    assign s1_adv     = r_s1_valid && !(r_s1_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // Clamp the row width and the current column
    always_comb begin
        w_eff = WW'(r_row_width);
        if (w_eff == '0) begin
            w_eff = WW'(1);
        end else if (w_eff > W_MAX) begin
            w_eff = W_MAX;
        end
        col_ext = WW'(r_col);
        c_ext   = (col_ext >= w_eff) ? w_eff - WW'(1) : col_ext;
        c_idx   = c_ext[CW-1:0];
        c_inc   = c_ext + WW'(1);
        row_end = (c_inc >= w_eff);
        win_ok  = (r_rows >= ROWS_WINDOW) && (c_ext >= WW'(2));
    end

    // Advance column and row count; drop both at the frame end
    always_comb begin
        n_col  = row_end ? '0 : c_inc[CW-1:0];
        n_rows = r_rows;
        if (row_end && (r_rows != ROWS_FULL)) begin
            n_rows = r_rows + 2'd1;
        end
        if (i_in_item.last_item) begin
            n_col  = '0;
            n_rows = '0;
        end
    end

    // Line buffers: the row above is written on acceptance, the row two above
    // when the update stage advances
    hsm_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_above (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(c_idx),
        .i_wdata(i_in_item.sample),
        .i_re   (accept),
        .i_raddr(c_idx),
        .o_rdata(rd_above)
    );

    hsm_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_two_above (
        .i_clk  (i_clk),
        .i_we   (s1_adv),
        .i_waddr(r_s1_addr),
        .i_wdata(up1),
        .i_re   (accept),
        .i_raddr(c_idx),
        .o_rdata(rd_two)
    );

    // Forward a same-column write that lands on the edge of the read
    assign up1 = rd_above;
    assign up2 = r_s1_fwd ? r_s1_fwd_data : rd_two;

    // Seven-term hourglass sum over the shifted window
    assign sum = t_sum'(r_win[0][1]) + t_sum'(r_win[0][2]) + t_sum'(up2)
               + t_sum'(r_win[1][2])
               + t_sum'(r_win[2][1]) + t_sum'(r_win[2][2]) + t_sum'(r_s1_sample);

    always_comb begin
        n_min      = r_min;
        n_have_min = r_have_min;
        if (r_s1_win && (!r_have_min || (sum < r_min))) begin
            n_min = sum;
        end
        if (r_s1_win) begin
            n_have_min = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_col       <= '0;
            r_rows      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_have_min  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_wdata;
            end
            if (accept) begin
                r_col  <= n_col;
                r_rows <= n_rows;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_min      <= r_s1_last ? '0 : n_min;
                r_have_min <= r_s1_last ? 1'b0 : n_have_min;
            end
            if (s1_adv && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Lookup stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample   <= i_in_item.sample;
            r_s1_addr     <= c_idx;
            r_s1_win      <= win_ok;
            r_s1_last     <= i_in_item.last_item;
            r_s1_fwd      <= s1_adv && (r_s1_addr == c_idx);
            r_s1_fwd_data <= up1;
        end
    end

    // Shift the window; clear it at the frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (s1_adv) begin
            if (r_s1_last) begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[r][k] <= '0;
                    end
                end
            end else begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= up2;
                r_win[1][2] <= up1;
                r_win[2][2] <= r_s1_sample;
            end
        end
    end

    // Load the frame result
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_item.min_sum   <= n_have_min ? MIN_SUM_BITS'(n_min) : '0;
            r_out_item.too_small <= !n_have_min;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/hsm_checker.sv
// Port-level checks for the hourglass stencil minimum block, and their bind.
// Depends on hsm_pkg and on hourglass_stencil_min_unit.
module hsm_checker
    import hsm_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic [ROW_WIDTH_BITS-1:0] i_cfg_wdata,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input t_in_item                  i_in_item,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input t_out_item                 o_out_item
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A too-small result carries a zero sum
    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.too_small |-> o_out_item.min_sum == '0)
        else $error("too-small result with nonzero sum");

    // A fresh result follows an accepted last-sample transaction
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && !o_in_stall && i_in_item.last_item, 2))
        else $error("result without a last sample");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

endmodule

bind hourglass_stencil_min_unit hsm_checker u_hsm_checker (.*);
